### hdl/indexed_ordered_list_core_macros.svh
// Assertion macros for the indexed ordered list core.
// No dependencies; included by modules that carry concurrent checks on clk/rst_n.
`ifndef INDEXED_ORDERED_LIST_CORE_MACROS_SVH
`define INDEXED_ORDERED_LIST_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define IOL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define IOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/iol_pkg.sv
// Shared types and codes for the indexed ordered list core.
// No dependencies; used by indexed_ordered_list_core.
package iol_pkg;

    localparam int POS_W    = 7;
    localparam int MODE_W   = 2;
    localparam int STATUS_W = 2;
    localparam int OUT_W    = 32;
    localparam int CNT_OUT_W = 7;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_DELETE = 2'd1;
    localparam mode_t MODE_READ   = 2'd2;
    localparam mode_t MODE_WRITE  = 2'd3;

    // Status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_RANGE = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

### hdl/indexed_ordered_list_core.sv
// Indexed ordered list: insert, delete, read and write at a list position.
// Depends on iol_pkg and indexed_ordered_list_core_macros.svh.
//
//  channel   | handshake          | payload
//  ----------+--------------------+------------------------------------
//  request   | start, busy        | mode, position, write_value
//  result    | done (1-cycle)     | status, read_value, entry_count
//
// Entries live in one synchronous RAM (one write, one read port, registered read).
// Insert and delete move one entry per cycle through the RAM read/write pair.
// Insert below count runs scan, tail, final and done; delete and read run scan,
// tail and done; an append, a write or any rejected request goes straight from
// start to done.
// Reset clears the state, the count and the read-valid flag; the RAM needs no clearing pass.
// A new request is taken once busy is low; done cannot be held off.
module indexed_ordered_list_core #(
    parameter int DEPTH       = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [iol_pkg::MODE_W-1:0]         mode,
    input  logic [iol_pkg::POS_W-1:0]          position,
    input  logic signed [iol_pkg::OUT_W-1:0]   write_value,
    output logic                               done,
    output logic [iol_pkg::STATUS_W-1:0]       status,
    output logic signed [iol_pkg::OUT_W-1:0]   read_value,
    output logic [iol_pkg::CNT_OUT_W-1:0]      entry_count
);

`include "indexed_ordered_list_core_macros.svh"

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_TAIL  = 3'd2;
    localparam logic [2:0] S_FINAL = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Entry storage
    logic [VALUE_WIDTH-1:0] mem [DEPTH];
    logic [VALUE_WIDTH-1:0] rd_data_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;

    // Control and payload registers
    logic [2:0]                   state_reg, state_next;
    logic [CW-1:0]                count_reg, count_next;
    iol_pkg::mode_t               op_reg, op_next;
    iol_pkg::status_t             status_reg, status_next;
    logic [AW-1:0]                pos_reg, pos_next;
    logic [AW-1:0]                src_reg, src_next;
    logic [AW-1:0]                end_reg, end_next;
    logic [VALUE_WIDTH-1:0]       wval_reg, wval_next;
    logic [iol_pkg::OUT_W-1:0]    rval_reg, rval_next;
    logic                         rd_valid_reg, rd_valid_next;
    logic [AW-1:0]                rd_src_reg, rd_src_next;

    logic                         accept;
    logic [XW-1:0]                pos_x;
    logic [XW-1:0]                cnt_x;
    logic [XW-1:0]                depth_x;
    logic [63:0]                  wval_wide;
    logic [63:0]                  rd_wide;
    logic [VALUE_WIDTH-1:0]       wval_in;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign pos_x     = XW'(position);
    assign cnt_x     = XW'(count_reg);
    assign depth_x   = XW'(DEPTH);
    assign wval_wide = 64'({1'b0, write_value}) & 64'h0000_0000_FFFF_FFFF;
    assign wval_in   = wval_wide[VALUE_WIDTH-1:0];
    assign rd_wide   = 64'(rd_data_reg);

    // Result port
    assign done        = (state_reg == S_DONE);
    assign status      = status_reg;
    assign read_value  = rval_reg;
    assign entry_count = iol_pkg::CNT_OUT_W'(count_reg);

    // Sequencer: evaluate on accept, stream reads, write back in the following cycle
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        src_next      = src_reg;
        end_next      = end_reg;
        wval_next     = wval_reg;
        rval_next     = rval_reg;
        rd_valid_next = 1'b0;
        rd_src_next   = src_reg;
        mem_we        = 1'b0;
        mem_waddr     = pos_reg;
        mem_wdata     = wval_reg;
        mem_re        = 1'b0;
        mem_raddr     = src_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = mode;
                    pos_next    = AW'(position);
                    wval_next   = wval_in;
                    rval_next   = '0;
                    status_next = iol_pkg::ST_OK;
                    state_next  = S_DONE;
                    if (mode == iol_pkg::MODE_INSERT)
                    begin
                        if (pos_x > cnt_x)
                            status_next = iol_pkg::ST_RANGE;
                        else if (cnt_x == depth_x)
                            status_next = iol_pkg::ST_FULL;
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            if (pos_x == cnt_x)
                            begin
                                // Append: no shift needed
                                mem_we    = 1'b1;
                                mem_waddr = AW'(position);
                                mem_wdata = wval_in;
                            end
                            else
                            begin
                                src_next   = AW'(count_reg - CW'(1));
                                end_next   = AW'(position);
                                state_next = S_SCAN;
                            end
                        end
                    end
                    else if (pos_x >= cnt_x)
                        status_next = iol_pkg::ST_RANGE;
                    else if (mode == iol_pkg::MODE_WRITE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(position);
                        mem_wdata = wval_in;
                    end
                    else
                    begin
                        src_next   = AW'(position);
                        state_next = S_SCAN;
                        if (mode == iol_pkg::MODE_DELETE)
                        begin
                            count_next = count_reg - CW'(1);
                            end_next   = AW'(count_reg - CW'(1));
                        end
                        else
                            end_next = AW'(position);
                    end
                end
            end
            S_SCAN, S_TAIL:
            begin
                // Issue the next read while scanning
                if (state_reg == S_SCAN)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = src_reg;
                    rd_valid_next = 1'b1;
                    rd_src_next   = src_reg;
                    if (src_reg == end_reg)
                        state_next = S_TAIL;
                    else if (op_reg == iol_pkg::MODE_INSERT)
                        src_next = src_reg - AW'(1);
                    else
                        src_next = src_reg + AW'(1);
                end
                else if (op_reg == iol_pkg::MODE_INSERT)
                    state_next = S_FINAL;
                else
                    state_next = S_DONE;

                // Retire the read issued last cycle
                if (rd_valid_reg)
                begin
                    if (op_reg == iol_pkg::MODE_INSERT)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = rd_src_reg + AW'(1);
                        mem_wdata = rd_data_reg;
                    end
                    else if (op_reg == iol_pkg::MODE_DELETE && rd_src_reg != pos_reg)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = rd_src_reg - AW'(1);
                        mem_wdata = rd_data_reg;
                    end
                    else
                        rval_next = rd_wide[iol_pkg::OUT_W-1:0];
                end
            end
            S_FINAL:
            begin
                // Drop the new value into the opened slot
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = wval_reg;
                state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        src_reg    <= src_next;
        end_reg    <= end_next;
        wval_reg   <= wval_next;
        rval_reg   <= rval_next;
        rd_src_reg <= rd_src_next;
    end

    // Entry RAM with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // Checks
    `IOL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `IOL_ASSERT_NEXT(a_done_idle, done, !busy, "not idle after result strobe")
    `IOL_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "count exceeds depth")
    `IOL_ASSERT_NOW(a_full_count, done && status == iol_pkg::ST_FULL, count_reg == CW'(DEPTH), "full status with room left")
    `IOL_ASSERT_NOW(a_ram_collide, mem_we && mem_re, mem_waddr != mem_raddr, "RAM read and write hit one entry")

endmodule
